// ----- rtl/bafc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafc_pkg
// Shared constants, codes and types for the binary audio frame checker.
// ----------------------------------------------------------------------------
package bafc_pkg;

	// Message layout
	localparam int HEADER_BYTES   = 64;
	localparam int COUNT_WIDTH    = 25;
	localparam int HDR_USED_BYTES = 32;

	// Field widths
	localparam int DATA_W    = 8;
	localparam int WORD_W    = 32;
	localparam int KIND_W    = 2;
	localparam int MAXRX_W   = 8;
	localparam int MAXMSG_W  = 24;
	localparam int CFG_IDX_W = 8;

	// Width that holds the header length plus four times any value count,
	// and any byte count.
	localparam int LEN_W = (COUNT_WIDTH > 35) ? COUNT_WIDTH : 35;

	// Header word slots (byte offset divided by four)
	localparam logic [2:0] SLOT_RECEIVER = 3'd0;
	localparam logic [2:0] SLOT_RATE     = 3'd1;
	localparam logic [2:0] SLOT_FORMAT   = 3'd2;
	localparam logic [2:0] SLOT_COUNT    = 3'd5;
	localparam logic [2:0] SLOT_TYPE     = 3'd6;
	localparam logic [2:0] SLOT_CHANNELS = 3'd7;

	// Header limits
	localparam logic [WORD_W-1:0] RATE_LOW      = 32'd8000;
	localparam logic [WORD_W-1:0] RATE_HIGH     = 32'd10000000;
	localparam logic [WORD_W-1:0] NEED_CHANNELS = 32'd2;
	localparam logic [WORD_W-1:0] TYPE_MAX      = 32'd3;
	localparam logic [KIND_W-1:0] KIND_CHRONO   = 2'd3;

	// Register reset values
	localparam logic [MAXRX_W-1:0]  RST_MAX_RECEIVERS = 8'd2;
	localparam logic [MAXMSG_W-1:0] RST_MAX_MSG_BYTES = 24'd65600;
	localparam logic [WORD_W-1:0]   RST_EXP_FORMAT    = 32'd3;

	// Command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef enum logic [3:0] {
		ERR_OK        = 4'd0,
		ERR_SHORT     = 4'd1,
		ERR_LARGE     = 4'd2,
		ERR_RECEIVER  = 4'd3,
		ERR_FORMAT    = 4'd4,
		ERR_RATE      = 4'd5,
		ERR_CHANNELS  = 4'd6,
		ERR_TYPE      = 4'd7,
		ERR_LENGTH    = 4'd8,
		ERR_NONFINITE = 4'd9
	} err_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_RECEIVERS = 8'd0,
		REG_MAX_MSG_BYTES = 8'd1,
		REG_EXP_FORMAT    = 8'd2
	} reg_idx_t;

	typedef struct packed {
		logic [MAXRX_W-1:0]  max_receivers;
		logic [MAXMSG_W-1:0] max_message_bytes;
		logic [WORD_W-1:0]   expected_format;
	} cfg_t;

	// One command from the front part: a sample, a summary or both.
	typedef struct packed {
		logic                   has_sample;
		logic                   has_summary;
		logic [WORD_W-1:0]      sample_word;
		logic                   sample_bad;
		logic [WORD_W-1:0]      receiver;
		logic [WORD_W-1:0]      rate;
		logic [WORD_W-1:0]      count;
		logic [KIND_W-1:0]      kind;
		logic [COUNT_WIDTH-1:0] size;
		err_t                   hdr_fault;
		logic                   bad_seen;
	} cmd_t;

	// One result beat
	typedef struct packed {
		logic              is_summary;
		logic [WORD_W-1:0] sample_bits;
		err_t              error_code;
		logic [WORD_W-1:0] receiver_id;
		logic [WORD_W-1:0] rate_value;
		logic [WORD_W-1:0] values_declared;
		logic [KIND_W-1:0] stream_kind;
	} res_t;

endpackage

// ----- rtl/bafc_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafc_cfg
// Configuration registers, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module bafc_cfg import bafc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register file; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_receivers     <= RST_MAX_RECEIVERS;
			cfg_q.max_message_bytes <= RST_MAX_MSG_BYTES;
			cfg_q.expected_format   <= RST_EXP_FORMAT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_RECEIVERS: cfg_q.max_receivers <= cfg_data[MAXRX_W-1:0];
				REG_MAX_MSG_BYTES: cfg_q.max_message_bytes <= cfg_data[MAXMSG_W-1:0];
				REG_EXP_FORMAT:    cfg_q.expected_format <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/bafc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafc_front
// Byte intake: counts bytes, assembles header words, checks the header and
// turns each byte into a sample and/or summary command.
// ----------------------------------------------------------------------------
module bafc_front import bafc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              accept,
	input  logic [DATA_W-1:0] data_byte,
	input  logic              last_byte,
	output logic              cmd_push,
	output cmd_t              cmd
);

	localparam logic [1:0] HB_LSB = 2'(HEADER_BYTES % 4);

	logic [COUNT_WIDTH-1:0] byte_cnt_q;
	logic [WORD_W-1:0]      word_q;
	logic [WORD_W-1:0]      receiver_q, rate_q, format_q, count_q, type_q, channels_q;
	logic                   bad_seen_q;

	logic                   sat;
	logic [COUNT_WIDTH-1:0] cnt_next;
	logic [WORD_W-1:0]      word_next;
	logic [WORD_W-1:0]      receiver_n, rate_n, format_n, count_n, type_n, channels_n;
	logic                   hdr_word_end;
	logic                   payload_word_end;
	logic [2:0]             slot;
	logic [1:0]             pay_phase;
	err_t                   fault;
	logic                   sample_fire;
	logic                   sample_bad;

	// Counter and word shifter
	always_comb begin
		sat       = &byte_cnt_q;
		cnt_next  = sat ? byte_cnt_q : byte_cnt_q + 1'b1;
		word_next = {data_byte, word_q[WORD_W-1:DATA_W]};
		slot      = byte_cnt_q[4:2];
		pay_phase = byte_cnt_q[1:0] - HB_LSB;
		hdr_word_end = !sat && (LEN_W'(byte_cnt_q) < LEN_W'(HDR_USED_BYTES))
			&& (byte_cnt_q[1:0] == 2'b11);
		payload_word_end = !sat && (LEN_W'(byte_cnt_q) >= LEN_W'(HEADER_BYTES))
			&& (pay_phase == 2'b11);
	end

	// Header word capture
	always_comb begin
		receiver_n = receiver_q;
		rate_n     = rate_q;
		format_n   = format_q;
		count_n    = count_q;
		type_n     = type_q;
		channels_n = channels_q;
		if (hdr_word_end) begin
			unique case (slot)
				SLOT_RECEIVER: receiver_n = word_next;
				SLOT_RATE:     rate_n     = word_next;
				SLOT_FORMAT:   format_n   = word_next;
				SLOT_COUNT:    count_n    = word_next;
				SLOT_TYPE:     type_n     = word_next;
				SLOT_CHANNELS: channels_n = word_next;
				default: ;
			endcase
		end
	end

	// Header checks in order of precedence. The header is complete long before
	// any byte for which the result matters.
	always_comb begin
		if (receiver_q >= WORD_W'(cfg.max_receivers)) begin
			fault = ERR_RECEIVER;
		end else if (format_q != cfg.expected_format) begin
			fault = ERR_FORMAT;
		end else if (rate_q < RATE_LOW || rate_q > RATE_HIGH) begin
			fault = ERR_RATE;
		end else if (channels_q != NEED_CHANNELS) begin
			fault = ERR_CHANNELS;
		end else if (type_q > TYPE_MAX) begin
			fault = ERR_TYPE;
		end else begin
			fault = ERR_OK;
		end
	end

	// Command for this byte
	always_comb begin
		sample_bad  = (word_next[30:23] == 8'hFF);
		sample_fire = payload_word_end && (fault == ERR_OK)
			&& (type_q[KIND_W-1:0] != KIND_CHRONO);
		cmd.has_sample  = sample_fire;
		cmd.has_summary = last_byte;
		cmd.sample_word = word_next;
		cmd.sample_bad  = sample_bad;
		cmd.receiver    = receiver_n;
		cmd.rate        = rate_n;
		cmd.count       = count_n;
		cmd.kind        = (type_n <= TYPE_MAX) ? type_n[KIND_W-1:0] : '0;
		cmd.size        = cnt_next;
		cmd.hdr_fault   = fault;
		cmd.bad_seen    = bad_seen_q || (sample_fire && sample_bad);
		cmd_push        = accept && (sample_fire || last_byte);
	end

	// Message state; everything returns to zero after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			word_q     <= '0;
			receiver_q <= '0;
			rate_q     <= '0;
			format_q   <= '0;
			count_q    <= '0;
			type_q     <= '0;
			channels_q <= '0;
			bad_seen_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				byte_cnt_q <= '0;
				word_q     <= '0;
				receiver_q <= '0;
				rate_q     <= '0;
				format_q   <= '0;
				count_q    <= '0;
				type_q     <= '0;
				channels_q <= '0;
				bad_seen_q <= 1'b0;
			end else begin
				byte_cnt_q <= cnt_next;
				word_q     <= word_next;
				receiver_q <= receiver_n;
				rate_q     <= rate_n;
				format_q   <= format_n;
				count_q    <= count_n;
				type_q     <= type_n;
				channels_q <= channels_n;
				bad_seen_q <= cmd.bad_seen;
			end
		end
	end

	// A sample is only ever issued once a whole payload word follows the header.
	a_sample_after_header: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && cmd.has_sample |-> LEN_W'(cmd.size) >= LEN_W'(HEADER_BYTES + 4))
		else $error("sample issued inside the header");

endmodule

// ----- rtl/bafc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafc_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module bafc_queue import bafc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign head_cmd = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command popped from an empty queue");

endmodule

// ----- rtl/bafc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafc_back
// Result side: evaluates the summary error and sends each command out as one
// or two result beats through an output register.
// ----------------------------------------------------------------------------
module bafc_back import bafc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [MAXMSG_W-1:0] max_message_bytes,
	input  cmd_t                q_cmd,
	input  logic                q_empty,
	output logic                q_pop,
	input  logic                res_pop,
	output logic                res_empty,
	output res_t                res
);

	logic           out_valid_q;
	logic           phase_q;
	res_t           res_q;

	logic           cur_is_sample;
	logic           load;
	logic [LEN_W-1:0] size_l;
	logic [LEN_W-1:0] expect_l;
	err_t           sum_err;
	res_t           res_next;

	// Summary error in order of precedence
	always_comb begin
		size_l   = LEN_W'(q_cmd.size);
		expect_l = LEN_W'(HEADER_BYTES) + LEN_W'({q_cmd.count, 2'b00});
		if (size_l < LEN_W'(HEADER_BYTES)) begin
			sum_err = ERR_SHORT;
		end else if (size_l > LEN_W'(max_message_bytes)) begin
			sum_err = ERR_LARGE;
		end else if (q_cmd.hdr_fault != ERR_OK) begin
			sum_err = q_cmd.hdr_fault;
		end else if (q_cmd.kind == KIND_CHRONO) begin
			sum_err = (size_l != LEN_W'(HEADER_BYTES)) ? ERR_LENGTH : ERR_OK;
		end else if (expect_l != size_l) begin
			sum_err = ERR_LENGTH;
		end else if (q_cmd.bad_seen) begin
			sum_err = ERR_NONFINITE;
		end else begin
			sum_err = ERR_OK;
		end
	end

	// Next result beat: the sample first, then the summary.
	always_comb begin
		cur_is_sample            = q_cmd.has_sample && !phase_q;
		res_next.is_summary      = !cur_is_sample;
		res_next.sample_bits     = cur_is_sample ? q_cmd.sample_word : '0;
		res_next.error_code      = cur_is_sample
			? (q_cmd.sample_bad ? ERR_NONFINITE : ERR_OK) : sum_err;
		res_next.receiver_id     = q_cmd.receiver;
		res_next.rate_value      = q_cmd.rate;
		res_next.values_declared = q_cmd.count;
		res_next.stream_kind     = q_cmd.kind;
		load  = !q_empty && (!out_valid_q || res_pop);
		q_pop = load && (!cur_is_sample || !q_cmd.has_summary);
	end

	assign res_empty = !out_valid_q;
	assign res       = res_q;

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_next;
		end
	end

	// Output valid and command phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= cur_is_sample && q_cmd.has_summary;
			end else if (res_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Phase is only set while a two-beat command waits at the queue head.
	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> !q_empty && q_cmd.has_sample && q_cmd.has_summary)
		else $error("second beat pending without a matching command");

endmodule

// ----- rtl/binary_audio_frame_checker.sv -----
`timescale 1ns / 1ps
// Path: a result beat passes the command queue and then the output register on its
// way from the byte that causes it to the output ports.
// Throughput: one byte per cycle while the queue has room; one result beat per cycle
// while popped; a byte ending both a payload word and the message gives two beats.
// Reset: clears the command queue, output register, byte counter and header
// words; the configuration registers return to their documented defaults.
// ----------------------------------------------------------------------------
// binary_audio_frame_checker
// Checks a byte stream message: header checks, payload samples, summary.
// ----------------------------------------------------------------------------
module binary_audio_frame_checker import bafc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [DATA_W-1:0]    data_byte,
	input  logic                 last_byte,
	output logic                 empty,
	input  logic                 pop,
	output logic                 is_summary,
	output logic [WORD_W-1:0]    sample_bits,
	output logic [3:0]           error_code,
	output logic [WORD_W-1:0]    receiver_id,
	output logic [WORD_W-1:0]    rate_value,
	output logic [WORD_W-1:0]    values_declared,
	output logic [KIND_W-1:0]    stream_kind,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	cfg_t cfg;
	logic accept;
	logic cmd_push;
	cmd_t cmd;
	logic q_full;
	logic q_empty;
	logic q_pop;
	cmd_t q_cmd;
	res_t res;

	// A byte beat is taken whenever the queue has room.
	assign full   = q_full;
	assign accept = push && !q_full;

	bafc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bafc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	bafc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head_cmd (q_cmd),
		.empty    (q_empty)
	);

	bafc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.max_message_bytes (cfg.max_message_bytes),
		.q_cmd             (q_cmd),
		.q_empty           (q_empty),
		.q_pop             (q_pop),
		.res_pop           (pop),
		.res_empty         (empty),
		.res               (res)
	);

	// Result fields
	assign is_summary      = res.is_summary;
	assign sample_bits     = res.sample_bits;
	assign error_code      = res.error_code;
	assign receiver_id     = res.receiver_id;
	assign rate_value      = res.rate_value;
	assign values_declared = res.values_declared;
	assign stream_kind     = res.stream_kind;

endmodule

// ----- tb/sv/binary_audio_frame_checker_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_audio_frame_checker_test
// Self-checking bench for the binary audio frame checker. Whole messages are
// pushed one byte per beat. Every accepted byte goes through a model of the
// header checks, the sample extraction and the summary rules, and each popped
// result beat is compared field by field with the oldest predicted beat.
// Directed messages cover the limits and each error, then random traffic runs
// under changing register settings with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module binary_audio_frame_checker_test;
	import bafc_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_FRAMES = 6;
	localparam logic [WORD_W-1:0] TYPICAL_RATE = 32'd48000;

	// Stimulus and observed ports.
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic [DATA_W-1:0]    data_byte = '0;
	logic                 last_byte = 1'b0;
	logic                 pop       = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data  = '0;
	logic                 full;
	logic                 empty;
	logic                 cfg_ready;
	logic                 is_summary;
	logic [WORD_W-1:0]    sample_bits;
	logic [3:0]           error_code;
	logic [WORD_W-1:0]    receiver_id;
	logic [WORD_W-1:0]    rate_value;
	logic [WORD_W-1:0]    values_declared;
	logic [KIND_W-1:0]    stream_kind;

	// Register shadow copies, starting from their reset values.
	logic [MAXRX_W-1:0]  cfg_rx  = RST_MAX_RECEIVERS;
	logic [MAXMSG_W-1:0] cfg_len = RST_MAX_MSG_BYTES;
	logic [WORD_W-1:0]   cfg_fmt = RST_EXP_FORMAT;

	// Message state of the predictor.
	logic [COUNT_WIDTH-1:0] byte_count = '0;
	logic [WORD_W-1:0]      word_sr    = '0;
	logic [WORD_W-1:0]      hdr_rx     = '0;
	logic [WORD_W-1:0]      hdr_rate   = '0;
	logic [WORD_W-1:0]      hdr_fmt    = '0;
	logic [WORD_W-1:0]      hdr_count  = '0;
	logic [WORD_W-1:0]      hdr_type   = '0;
	logic [WORD_W-1:0]      hdr_chans  = '0;
	logic                   bad_seen   = 1'b0;

	res_t              result_q[$];
	logic [DATA_W-1:0] frame_q[$];
	int                fault_count  = 0;
	logic              sender_idles = 1'b1;
	logic              sink_stalls  = 1'b1;

	binary_audio_frame_checker u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.empty           (empty),
		.pop             (pop),
		.is_summary      (is_summary),
		.sample_bits     (sample_bits),
		.error_code      (error_code),
		.receiver_id     (receiver_id),
		.rate_value      (rate_value),
		.values_declared (values_declared),
		.stream_kind     (stream_kind),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Header checks in order of precedence.
	function automatic err_t header_fault();
		if (cfg_rx == '0 || hdr_rx >= WORD_W'(cfg_rx)) return ERR_RECEIVER;
		if (hdr_fmt != cfg_fmt) return ERR_FORMAT;
		if (hdr_rate < RATE_LOW || hdr_rate > RATE_HIGH) return ERR_RATE;
		if (hdr_chans != NEED_CHANNELS) return ERR_CHANNELS;
		if (hdr_type > TYPE_MAX) return ERR_TYPE;
		return ERR_OK;
	endfunction

	task automatic expect_beat(input logic summary, input logic [WORD_W-1:0] bits,
			input err_t code);
		res_t r;
		r.is_summary      = summary;
		r.sample_bits     = bits;
		r.error_code      = code;
		r.receiver_id     = hdr_rx;
		r.rate_value      = hdr_rate;
		r.values_declared = hdr_count;
		r.stream_kind     = (hdr_type <= TYPE_MAX) ? hdr_type[KIND_W-1:0] : '0;
		result_q.insert(result_q.size(), r);
	endtask

	// Works out the result beats caused by one accepted byte.
	task automatic take_byte(input logic [DATA_W-1:0] b, input logic lst);
		logic [COUNT_WIDTH-1:0] pos;
		logic [LEN_W-1:0]       want_len;
		err_t                   verdict;
		logic                   bad;
		pos = byte_count;
		word_sr = {b, word_sr[WORD_W-1:DATA_W]};
		if (pos != {COUNT_WIDTH{1'b1}}) begin
			byte_count = pos + 1'b1;
			if (LEN_W'(pos) < LEN_W'(HEADER_BYTES)) begin
				// Only the first eight header words carry fields.
				if (pos[1:0] == 2'b11 && LEN_W'(pos) < LEN_W'(HDR_USED_BYTES)) begin
					case (pos[4:2])
						SLOT_RECEIVER: hdr_rx    = word_sr;
						SLOT_RATE:     hdr_rate  = word_sr;
						SLOT_FORMAT:   hdr_fmt   = word_sr;
						SLOT_COUNT:    hdr_count = word_sr;
						SLOT_TYPE:     hdr_type  = word_sr;
						SLOT_CHANNELS: hdr_chans = word_sr;
						default: ;
					endcase
				end
			end else if (2'(pos - COUNT_WIDTH'(HEADER_BYTES)) == 2'b11 &&
					header_fault() == ERR_OK && hdr_type != WORD_W'(KIND_CHRONO)) begin
				bad = (word_sr[30:23] == 8'hFF);
				if (bad) bad_seen = 1'b1;
				expect_beat(1'b0, word_sr, bad ? ERR_NONFINITE : ERR_OK);
			end
		end
		if (lst) begin
			if (LEN_W'(byte_count) < LEN_W'(HEADER_BYTES)) begin
				verdict = ERR_SHORT;
			end else if (LEN_W'(byte_count) > LEN_W'(cfg_len)) begin
				verdict = ERR_LARGE;
			end else begin
				verdict = header_fault();
				if (verdict == ERR_OK) begin
					if (hdr_type == WORD_W'(KIND_CHRONO)) begin
						if (LEN_W'(byte_count) != LEN_W'(HEADER_BYTES)) verdict = ERR_LENGTH;
					end else begin
						want_len = LEN_W'(HEADER_BYTES) + LEN_W'({hdr_count, 2'b00});
						if (want_len != LEN_W'(byte_count)) verdict = ERR_LENGTH;
						else if (bad_seen) verdict = ERR_NONFINITE;
					end
				end
			end
			expect_beat(1'b1, '0, verdict);
			byte_count = '0;
			word_sr    = '0;
			hdr_rx     = '0;
			hdr_rate   = '0;
			hdr_fmt    = '0;
			hdr_count  = '0;
			hdr_type   = '0;
			hdr_chans  = '0;
			bad_seen   = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, want, got);
			fault_count++;
		end
	endtask

	task automatic check_beat();
		res_t want;
		if (result_q.size() == 0) begin
			$display("%0t ns: result beat with none expected, actual sample 0x%0h code %0d",
				$time, sample_bits, error_code);
			fault_count++;
		end else begin
			want = result_q.pop_front();
			check_field("is_summary", WORD_W'(want.is_summary), WORD_W'(is_summary));
			check_field("sample_bits", want.sample_bits, sample_bits);
			check_field("error_code", WORD_W'(want.error_code), WORD_W'(error_code));
			check_field("receiver_id", want.receiver_id, receiver_id);
			check_field("rate_value", want.rate_value, rate_value);
			check_field("values_declared", want.values_declared, values_declared);
			check_field("stream_kind", WORD_W'(want.stream_kind), WORD_W'(stream_kind));
		end
	endtask

	// Register writes, bytes and result beats, all taken at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_RECEIVERS: cfg_rx  = cfg_data[MAXRX_W-1:0];
					REG_MAX_MSG_BYTES: cfg_len = cfg_data[MAXMSG_W-1:0];
					REG_EXP_FORMAT:    cfg_fmt = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) take_byte(data_byte, last_byte);
			if (pop && !empty) check_beat();
		end
	end

	// The result side pops after a random stall drawn for every beat.
	initial begin : result_sink
		int gap;
		wait (arst_n);
		forever begin
			@(negedge clk);
			gap = sink_stalls ? $urandom_range(0, 18) : 0;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// Ends the run when nothing has been accepted for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("binary_audio_frame_checker_test NOT OK");
		$finish;
	end

	// Offers one byte after a random gap and returns at the next falling edge.
	task automatic send_byte(input logic [DATA_W-1:0] b, input logic lst);
		int gap;
		gap = sender_idles ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push      <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	// Holds the input off until every predicted beat has been popped.
	task automatic quiesce();
		push <= 1'b0;
		do @(negedge clk); while (result_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register beat; valid is then dropped on the channel before the task returns.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_registers(input logic [MAXRX_W-1:0] rx, input logic [MAXMSG_W-1:0] len,
			input logic [WORD_W-1:0] fmt);
		quiesce();
		write_reg(REG_MAX_RECEIVERS, WORD_W'(rx));
		write_reg(REG_MAX_MSG_BYTES, WORD_W'(len));
		write_reg(REG_EXP_FORMAT, fmt);
	endtask

	task automatic put_word(input logic [WORD_W-1:0] w);
		for (int i = 0; i < WORD_W / DATA_W; i++)
			frame_q.insert(frame_q.size(), w[i*DATA_W +: DATA_W]);
	endtask

	// Builds a header with random filler, then random payload words, some of
	// them with the exponent forced to all ones.
	task automatic make_frame(input logic [WORD_W-1:0] rx, input logic [WORD_W-1:0] rate,
			input logic [WORD_W-1:0] fmt, input logic [WORD_W-1:0] count,
			input logic [WORD_W-1:0] kind, input logic [WORD_W-1:0] chans, input int words);
		logic [WORD_W-1:0] w;
		frame_q.delete();
		for (int slot = 0; slot < HEADER_BYTES / 4; slot++) begin
			case (slot)
				int'(SLOT_RECEIVER): w = rx;
				int'(SLOT_RATE):     w = rate;
				int'(SLOT_FORMAT):   w = fmt;
				int'(SLOT_COUNT):    w = count;
				int'(SLOT_TYPE):     w = kind;
				int'(SLOT_CHANNELS): w = chans;
				default:             w = $urandom;
			endcase
			put_word(w);
		end
		for (int i = 0; i < words; i++) begin
			w = $urandom;
			if ($urandom_range(0, 3) == 0) w[30:23] = 8'hFF;
			put_word(w);
		end
	endtask

	// Sends the built message; optionally waits for all results mid-way.
	task automatic send_frame(input int pause_at);
		for (int i = 0; i < frame_q.size(); i++) begin
			if (i == pause_at) quiesce();
			send_byte(frame_q[i], i == frame_q.size() - 1);
		end
	endtask

	task automatic send_random_bytes(input int n);
		frame_q.delete();
		repeat (n) frame_q.insert(frame_q.size(), DATA_W'($urandom));
		send_frame(-1);
	endtask

	// Accepted messages with ordinary and non-finite samples, rate limits and
	// a header-only chrono frame.
	task automatic test_good_frames();
		make_frame(1, TYPICAL_RATE, cfg_fmt, 3, 0, NEED_CHANNELS, 0);
		put_word(32'h0000_0000);
		put_word(32'h7F80_0000);
		put_word(32'hFF7F_FFFF);
		send_frame(-1);
		make_frame(0, RATE_LOW, cfg_fmt, 2, 1, NEED_CHANNELS, 2);
		send_frame(-1);
		make_frame(1, RATE_HIGH, cfg_fmt, 0, 2, NEED_CHANNELS, 0);
		send_frame(-1);
		make_frame(1, TYPICAL_RATE, cfg_fmt, 5, WORD_W'(KIND_CHRONO), NEED_CHANNELS, 0);
		send_frame(-1);
	endtask

	// Each header error, with payload present that must give no samples.
	task automatic test_header_faults();
		make_frame(WORD_W'(cfg_rx), TYPICAL_RATE, cfg_fmt, 2, 0, NEED_CHANNELS, 2);
		send_frame(-1);
		make_frame(0, TYPICAL_RATE, cfg_fmt + 1, 2, 0, NEED_CHANNELS, 2);
		send_frame(-1);
		make_frame(0, RATE_LOW - 1, cfg_fmt, 2, 1, NEED_CHANNELS, 2);
		send_frame(-1);
		make_frame(0, RATE_HIGH + 1, cfg_fmt, 2, 1, NEED_CHANNELS, 2);
		send_frame(-1);
		make_frame(1, TYPICAL_RATE, cfg_fmt, 2, 2, NEED_CHANNELS + 1, 2);
		send_frame(-1);
		make_frame(1, TYPICAL_RATE, cfg_fmt, 2, TYPE_MAX + 1, NEED_CHANNELS, 2);
		send_frame(-1);
		// Every field wrong: the receiver error wins.
		make_frame('1, '1, ~cfg_fmt, '1, '1, '1, 2);
		send_frame(-1);
	endtask

	// Short messages, count mismatches, a trailing partial word and counts
	// whose byte length does not fit in 32 bits.
	task automatic test_length_faults();
		send_random_bytes(1);
		send_random_bytes(HEADER_BYTES - 1);
		make_frame(1, TYPICAL_RATE, cfg_fmt, 2, 0, NEED_CHANNELS, 3);
		send_frame(-1);
		make_frame(1, TYPICAL_RATE, cfg_fmt, 2, 0, NEED_CHANNELS, 2);
		repeat (3) frame_q.insert(frame_q.size(), DATA_W'($urandom));
		send_frame(-1);
		make_frame(1, TYPICAL_RATE, cfg_fmt, 32'h4000_0001, 1, NEED_CHANNELS, 1);
		send_frame(-1);
		make_frame(1, TYPICAL_RATE, cfg_fmt, 32'hFFFF_FFFF, 2, NEED_CHANNELS, 1);
		send_frame(-1);
		make_frame(1, TYPICAL_RATE, cfg_fmt, 0, WORD_W'(KIND_CHRONO), NEED_CHANNELS, 1);
		send_frame(-1);
	endtask

	// Register extremes, a write to an unused index, and back to reset values.
	task automatic test_register_limits();
		set_registers('0, RST_MAX_MSG_BYTES, RST_EXP_FORMAT);
		make_frame(0, TYPICAL_RATE, cfg_fmt, 1, 0, NEED_CHANNELS, 1);
		send_frame(-1);
		set_registers('1, '1, '1);
		make_frame(254, TYPICAL_RATE, cfg_fmt, 2, 1, NEED_CHANNELS, 2);
		send_frame(-1);
		make_frame(255, TYPICAL_RATE, cfg_fmt, 2, 1, NEED_CHANNELS, 2);
		send_frame(-1);
		set_registers(MAXRX_W'(1), '0, '0);
		send_random_bytes(10);
		make_frame(0, TYPICAL_RATE, cfg_fmt, 0, 0, NEED_CHANNELS, 0);
		send_frame(-1);
		set_registers(MAXRX_W'(1), MAXMSG_W'(HEADER_BYTES + 8), '0);
		make_frame(0, TYPICAL_RATE, cfg_fmt, 2, 2, NEED_CHANNELS, 2);
		send_frame(-1);
		make_frame(0, TYPICAL_RATE, cfg_fmt, 3, 2, NEED_CHANNELS, 3);
		send_frame(-1);
		quiesce();
		write_reg(CFG_IDX_W'($urandom_range(REG_EXP_FORMAT + 1, 2**CFG_IDX_W - 1)), $urandom);
		make_frame(0, TYPICAL_RATE, cfg_fmt, 1, 0, NEED_CHANNELS, 1);
		send_frame(-1);
		set_registers(RST_MAX_RECEIVERS, RST_MAX_MSG_BYTES, RST_EXP_FORMAT);
	endtask

	// Back-to-back bytes into a stalling sink, with the sender holding off
	// mid-message until the sink has caught up.
	task automatic test_backpressure();
		sender_idles = 1'b0;
		make_frame(1, TYPICAL_RATE, cfg_fmt, 12, 0, NEED_CHANNELS, 12);
		send_frame(HEADER_BYTES + 22);
		make_frame(0, TYPICAL_RATE, cfg_fmt, 6, 1, NEED_CHANNELS, 6);
		send_frame(HEADER_BYTES / 2);
		sender_idles = 1'b1;
	endtask

	// Mostly well-formed messages with random content, the rest broken.
	task automatic send_random_frame(input int pause_at);
		logic [WORD_W-1:0] rx, rate, fmt, count, kind, chans;
		int                words, pick;
		pick  = $urandom_range(0, 19);
		rx    = (cfg_rx == '0) ? $urandom : $urandom_range(0, cfg_rx - 1);
		rate  = $urandom_range(RATE_LOW, RATE_HIGH);
		fmt   = cfg_fmt;
		chans = NEED_CHANNELS;
		kind  = $urandom_range(0, TYPE_MAX);
		words = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
		count = words;
		if (kind == WORD_W'(KIND_CHRONO)) words = ($urandom_range(0, 5) == 0) ? 1 : 0;
		case (pick)
			12: rx = $urandom_range(0, 1) ? ($urandom | 32'h100) : cfg_rx + $urandom_range(0, 3);
			13: fmt = cfg_fmt ^ (32'd1 << $urandom_range(0, 31));
			14: rate = $urandom_range(0, 1) ? $urandom_range(0, RATE_LOW - 1)
				: $urandom_range(RATE_HIGH + 1, 32'hFFFF_FFFF);
			15: chans = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1);
			16: kind = $urandom_range(0, 1) ? $urandom_range(TYPE_MAX + 1, 7)
				: ($urandom | 32'h8000_0000);
			17: count = $urandom_range(0, 1) ? $urandom : count + $urandom_range(1, 2);
			default: ;
		endcase
		make_frame(rx, rate, fmt, count, kind, chans, words);
		if (pick == 18)
			repeat ($urandom_range(1, 3)) frame_q.insert(frame_q.size(), DATA_W'($urandom));
		if (pick == 19) begin
			frame_q = frame_q[0:$urandom_range(0, HEADER_BYTES - 2)];
		end
		send_frame(pause_at);
	endtask

	task automatic test_random_traffic();
		int                  frames, pause_at;
		logic [MAXRX_W-1:0]  rx;
		logic [MAXMSG_W-1:0] len;
		logic [WORD_W-1:0]   fmt;
		frames = 0;
		while (frames < RANDOM_FRAMES) begin
			// A new register setting and idling pattern every few messages.
			if (frames % 3 == 0) begin
				case ($urandom_range(0, 9))
					0:       rx = '0;
					1:       rx = MAXRX_W'(1);
					2:       rx = '1;
					default: rx = MAXRX_W'($urandom_range(2, 254));
				endcase
				case ($urandom_range(0, 5))
					0:       len = MAXMSG_W'($urandom_range(HEADER_BYTES, 200));
					1:       len = RST_MAX_MSG_BYTES;
					2:       len = '1;
					default: len = MAXMSG_W'($urandom_range(200, 70000));
				endcase
				case ($urandom_range(0, 3))
					0:       fmt = RST_EXP_FORMAT;
					1:       fmt = $urandom;
					2:       fmt = '1;
					default: fmt = '0;
				endcase
				set_registers(rx, len, fmt);
				sender_idles = ($urandom_range(0, 2) != 0);
				sink_stalls  = ($urandom_range(0, 2) != 0);
			end
			pause_at = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 90) : -1;
			send_random_frame(pause_at);
			frames++;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_good_frames();
		test_header_faults();
		test_length_faults();
		test_register_limits();
		test_backpressure();
		test_random_traffic();
		quiesce();
		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		if (fault_count == 0)
			$display("binary_audio_frame_checker_test OK");
		else
			$display("binary_audio_frame_checker_test NOT OK");
		$finish;
	end

endmodule
